FILE: design/hsv_pkg.sv
// Shared constants for the HSV to RGB converter: field widths, hue format
// and the reciprocal used for the final divide. No dependencies.
package hsv_pkg;

  localparam int HSV_HUE_FRAC_BITS = 4;
  localparam int HSV_HUE_W         = 14;
  localparam int HSV_PCT_W         = 8;
  localparam int HSV_CH_W          = 8;
  localparam int HSV_S_DATA_W      = 32;
  localparam int HSV_M_DATA_W      = 24;

  // floor(z / 9375) == (z * HSV_RECIP) >> HSV_RECIP_SHIFT for z < 2**HSV_Z_W
  localparam int          HSV_Z_W         = 22;
  localparam int          HSV_RECIP_W     = 23;
  localparam int          HSV_RECIP_SHIFT = 36;
  localparam logic [22:0] HSV_RECIP       = 23'd7330078;

endpackage

FILE: design/hsv_to_rgb_converter.sv
// HSV to RGB converter, five-stage pipeline, one pixel per clock unless stalled.
// Depends on hsv_pkg for widths and the reciprocal constant.
//
//  channel  | dir | tdata (low bit up)                | tuser
//  ---------+-----+-----------------------------------+--------
//  s_axis   | in  | hue[13:0], saturation[7:0],       | -
//           |     | brightness[7:0], 2 zero bits      |
//  m_axis   | out | red[7:0], green[7:0], blue[7:0]   | invalid
//
// Words pass the stage registers in order; unless the output stalls, one word
// enters per cycle. The last stage holds the result register, and each stage
// advances when it is empty or the stage after it advances, so bubbles fill.
// The longest path is the chroma/hue product in stage 2 or the reciprocal
// multiply into the output register. Reset clears the valid bits only.
module hsv_to_rgb_converter import hsv_pkg::*; #(
  parameter int HueFracBits = HSV_HUE_FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [HSV_S_DATA_W-1:0] s_axis_tdata_i,  // hue, saturation, brightness
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [HSV_M_DATA_W-1:0] m_axis_tdata_o,  // red, green, blue
  output logic                    m_axis_tuser_o   // invalid
);

  localparam int NumStages = 5;
  localparam int Per       = 60 << HueFracBits;
  localparam int Full      = 360 << HueFracBits;
  localparam int PerW      = $clog2(Per + 1);
  localparam int OffW      = $clog2(Full + 1) + 1;
  localparam int TW        = $clog2(100 * Per + 1);
  localparam int BW        = TW + 7;
  localparam int ScW       = BW + 8;
  localparam int PW        = HSV_Z_W + HSV_RECIP_W;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;

  // Stage 1: range check and sector
  logic signed [HSV_HUE_W-1:0] hue_s;
  logic signed [HSV_PCT_W-1:0] sat_s, val_s;
  logic [HSV_HUE_W-2:0]        deg;
  logic [2:0]                  sector_d, sector_q;
  logic                        bad_d;
  logic [HSV_HUE_W-2:0]        hue_q;
  logic [6:0]                  sat_q, val1_q;
  logic                        bad1_q;

  // Stage 2: per-channel weights
  logic [OffW-1:0]  off;
  logic [OffW-1:0]  pos_full;
  logic [PerW-1:0]  pos, kpos;
  logic [PerW-1:0]  kk [3];
  logic [TW-1:0]    t_d [3];
  logic [TW-1:0]    t_q [3];
  logic [6:0]       val2_q;
  logic             bad2_q;

  // Stage 3 and 4: scale by value, then by 255 over the power-of-two part
  logic [BW-1:0]       b_q [3];
  logic                bad3_q;
  logic [ScW-1:0]      sc [3];
  logic [HSV_Z_W-1:0]  z_q [3];
  logic                bad4_q;

  // Stage 5: reciprocal multiply into the output register
  logic [PW-1:0]       prod [3];
  logic [HSV_CH_W-1:0] ch_q [3];
  logic                inv_q;

  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign s_axis_tready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid_i;
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // ---------------- stage 1 ----------------
  assign hue_s = signed'(s_axis_tdata_i[HSV_HUE_W-1:0]);
  assign sat_s = signed'(s_axis_tdata_i[HSV_HUE_W +: HSV_PCT_W]);
  assign val_s = signed'(s_axis_tdata_i[HSV_HUE_W+HSV_PCT_W +: HSV_PCT_W]);
  assign deg   = s_axis_tdata_i[HSV_HUE_W-2:0] >> HueFracBits;

  always_comb begin
    bad_d = (hue_s < 0) || (int'(hue_s) > Full) || (sat_s < 0) || (sat_s > 8'sd100)
         || (val_s < 0) || (val_s > 8'sd100);
    if      (deg < (HSV_HUE_W-1)'(60))  sector_d = 3'd0;
    else if (deg < (HSV_HUE_W-1)'(120)) sector_d = 3'd1;
    else if (deg < (HSV_HUE_W-1)'(180)) sector_d = 3'd2;
    else if (deg < (HSV_HUE_W-1)'(240)) sector_d = 3'd3;
    else if (deg < (HSV_HUE_W-1)'(300)) sector_d = 3'd4;
    else if (deg < (HSV_HUE_W-1)'(360)) sector_d = 3'd5;
    else                                sector_d = 3'd6;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      hue_q    <= s_axis_tdata_i[HSV_HUE_W-2:0];
      sat_q    <= sat_s[6:0];
      val1_q   <= val_s[6:0];
      sector_q <= sector_d;
      bad1_q   <= bad_d;
    end
  end

  // ---------------- stage 2 ----------------
  // Distance into the sector, mirrored in odd sectors.
  always_comb begin
    off      = OffW'(sector_q) * OffW'(Per);
    pos_full = OffW'(hue_q) - off;
    pos      = pos_full[PerW-1:0];
    kpos     = sector_q[0] ? PerW'(Per) - pos : pos;
    case (sector_q)
      3'd0:    begin kk[0] = PerW'(Per); kk[1] = kpos;       kk[2] = '0;         end
      3'd1:    begin kk[0] = kpos;       kk[1] = PerW'(Per); kk[2] = '0;         end
      3'd2:    begin kk[0] = '0;         kk[1] = PerW'(Per); kk[2] = kpos;       end
      3'd3:    begin kk[0] = '0;         kk[1] = kpos;       kk[2] = PerW'(Per); end
      3'd4:    begin kk[0] = kpos;       kk[1] = '0;         kk[2] = PerW'(Per); end
      default: begin kk[0] = PerW'(Per); kk[1] = '0;         kk[2] = kpos;       end
    endcase
    for (int c = 0; c < 3; c++) begin
      t_d[c] = TW'(sat_q) * TW'(kk[c]) + TW'(Per) * TW'(7'd100 - sat_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      t_q    <= t_d;
      val2_q <= val1_q;
      bad2_q <= bad1_q;
    end
  end

  // ---------------- stage 3 ----------------
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int c = 0; c < 3; c++) begin
        b_q[c] <= BW'(val2_q) * BW'(t_q[c]);
      end
      bad3_q <= bad2_q;
    end
  end

  // ---------------- stage 4 ----------------
  // 255*b, then drop the hue fraction bits and the 64 factor of 600000.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sc[c] = {b_q[c], 8'b0} - ScW'(b_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int c = 0; c < 3; c++) begin
        z_q[c] <= HSV_Z_W'(sc[c] >> (HueFracBits + 6));
      end
      bad4_q <= bad3_q;
    end
  end

  // ---------------- stage 5 ----------------
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PW'(z_q[c]) * PW'(HSV_RECIP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int c = 0; c < 3; c++) begin
        ch_q[c] <= bad4_q ? '0 : prod[c][HSV_RECIP_SHIFT +: HSV_CH_W];
      end
      inv_q <= bad4_q;
    end
  end

  assign m_axis_tvalid_o = vld_q[NumStages-1];
  assign m_axis_tdata_o  = {ch_q[2], ch_q[1], ch_q[0]};
  assign m_axis_tuser_o  = inv_q;

endmodule

FILE: design/hsv_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the top level.
// Depends on hsv_pkg for port widths.
module hsv_checker import hsv_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    s_axis_tready_o,
  input logic                    m_axis_tvalid_o,
  input logic                    m_axis_tready_i,
  input logic [HSV_M_DATA_W-1:0] m_axis_tdata_o,
  input logic                    m_axis_tuser_o
);

  // Out-of-range pixels come out black.
  a_invalid_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("invalid word carries nonzero color");

  // An empty output register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // Reset empties the pipeline at once.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output word changed");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for hsv_to_rgb_converter: drives HSV pixel words with bursty input and a
// stalling output; checks every word against a listed color or exact integer predictor.
// Depends on hsv_pkg and the converter RTL.
module testbench;
  import hsv_pkg::*;

  localparam int  HUE_PER_SECTOR = 60 << HSV_HUE_FRAC_BITS;
  localparam int  HUE_FULL_TURN  = 360 << HSV_HUE_FRAC_BITS;
  localparam int  PCT_MAX        = 100;
  localparam longint COLOR_DEN   = 64'd10000 * HUE_PER_SECTOR;
  localparam int  RANDOM_PIXELS  = 800;
  localparam int  DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic [HSV_CH_W-1:0] red;
    logic [HSV_CH_W-1:0] green;
    logic [HSV_CH_W-1:0] blue;
    logic                invalid;
  } rgb_t;

  typedef struct packed {
    logic signed [HSV_HUE_W-1:0] hue;
    logic signed [HSV_PCT_W-1:0] sat;
    logic signed [HSV_PCT_W-1:0] val;
    logic                        typed;  // want holds a hand-written color
    rgb_t                        want;
  } pixel_row_t;

  localparam rgb_t OUT_OF_RANGE = '{8'd0, 8'd0, 8'd0, 1'b1};
  localparam rgb_t NO_COLOR     = '{8'd0, 8'd0, 8'd0, 1'b0};
  localparam int   NUM_DIRECTED = 25;
  localparam int   MAX_PIXELS   = NUM_DIRECTED + RANDOM_PIXELS;

  // hue in 1/16 degree: 960 = 60, 5760 = 360
  localparam pixel_row_t DIRECTED [NUM_DIRECTED] = '{
    '{14'sd0,     8'sd0,    8'sd0,    1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
    '{14'sd0,     8'sd100,  8'sd100,  1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
    '{14'sd960,   8'sd100,  8'sd100,  1'b1, '{8'd255, 8'd255, 8'd0,   1'b0}},
    '{14'sd1920,  8'sd100,  8'sd100,  1'b1, '{8'd0,   8'd255, 8'd0,   1'b0}},
    '{14'sd2880,  8'sd100,  8'sd100,  1'b1, '{8'd0,   8'd255, 8'd255, 1'b0}},
    '{14'sd3840,  8'sd100,  8'sd100,  1'b1, '{8'd0,   8'd0,   8'd255, 1'b0}},
    '{14'sd4800,  8'sd100,  8'sd100,  1'b1, '{8'd255, 8'd0,   8'd255, 1'b0}},
    '{14'sd5760,  8'sd100,  8'sd100,  1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
    '{14'sd2000,  8'sd0,    8'sd100,  1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
    '{14'sd5761,  8'sd100,  8'sd100,  1'b1, OUT_OF_RANGE},
    '{-14'sd1,    8'sd50,   8'sd50,   1'b1, OUT_OF_RANGE},
    '{-14'sd8192, 8'sd50,   8'sd50,   1'b1, OUT_OF_RANGE},
    '{14'sd8191,  8'sd50,   8'sd50,   1'b1, OUT_OF_RANGE},
    '{14'sd100,   -8'sd1,   8'sd50,   1'b1, OUT_OF_RANGE},
    '{14'sd100,   8'sd101,  8'sd50,   1'b1, OUT_OF_RANGE},
    '{14'sd100,   8'sd127,  8'sd50,   1'b1, OUT_OF_RANGE},
    '{14'sd100,   -8'sd128, 8'sd50,   1'b1, OUT_OF_RANGE},
    '{14'sd100,   8'sd50,   -8'sd1,   1'b1, OUT_OF_RANGE},
    '{14'sd100,   8'sd50,   8'sd101,  1'b1, OUT_OF_RANGE},
    '{14'sd100,   8'sd50,   8'sd127,  1'b1, OUT_OF_RANGE},
    '{14'sd100,   8'sd50,   -8'sd128, 1'b1, OUT_OF_RANGE},
    '{14'sd1,     8'sd50,   8'sd50,   1'b0, NO_COLOR},
    '{14'sd5759,  8'sd100,  8'sd100,  1'b0, NO_COLOR},
    '{14'sd959,   8'sd73,   8'sd88,   1'b0, NO_COLOR},
    '{14'sd1234,  8'sd100,  8'sd1,    1'b0, NO_COLOR}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [HSV_S_DATA_W-1:0] s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [HSV_M_DATA_W-1:0] m_axis_tdata;
  logic                    m_axis_tuser;

  // expected colors in send order, indexed by pixels_sent and colors_seen
  rgb_t expected_colors [MAX_PIXELS];
  int   mismatches   = 0;
  int   pixels_sent  = 0;
  int   pixels_bad   = 0;
  int   colors_seen  = 0;
  int   cycle_count  = 0;
  logic [12:0] stall_pattern = 13'b1101100111010;

  hsv_to_rgb_converter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Exact color over the common denominator, one truncation at the end.
  function automatic rgb_t hsv_color(logic signed [HSV_HUE_W-1:0] hue,
                                     logic signed [HSV_PCT_W-1:0] sat,
                                     logic signed [HSV_PCT_W-1:0] val);
    longint h, s, v, chroma, base, tilt, phase, sector;
    longint lvl [3];
    rgb_t   res;
    h = longint'(hue);
    s = longint'(sat);
    v = longint'(val);
    if (h < 0 || h > HUE_FULL_TURN || s < 0 || s > PCT_MAX || v < 0 || v > PCT_MAX)
      return OUT_OF_RANGE;
    chroma = s * v * HUE_PER_SECTOR;
    base   = v * PCT_MAX * HUE_PER_SECTOR - chroma;
    phase  = h % (2 * HUE_PER_SECTOR);
    if (phase >= HUE_PER_SECTOR) phase = 2 * HUE_PER_SECTOR - phase;
    tilt   = s * v * phase;
    sector = h / HUE_PER_SECTOR;
    case (sector)
      0: lvl = '{chroma, tilt, 0};
      1: lvl = '{tilt, chroma, 0};
      2: lvl = '{0, chroma, tilt};
      3: lvl = '{0, tilt, chroma};
      4: lvl = '{tilt, 0, chroma};
      default: lvl = '{chroma, 0, tilt};
    endcase
    res.red     = HSV_CH_W'(((lvl[0] + base) * 255) / COLOR_DEN);
    res.green   = HSV_CH_W'(((lvl[1] + base) * 255) / COLOR_DEN);
    res.blue    = HSV_CH_W'(((lvl[2] + base) * 255) / COLOR_DEN);
    res.invalid = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] %s mismatch on color %0d: got %0d, want %0d",
             $realtime, field, colors_seen, got, want);
    mismatches++;
  endtask

  // Drive one pixel word at the falling edge and hold it until accepted.
  task automatic push_pixel(logic signed [HSV_HUE_W-1:0] hue,
                            logic signed [HSV_PCT_W-1:0] sat,
                            logic signed [HSV_PCT_W-1:0] val,
                            rgb_t want);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b00, val, sat, hue};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_colors[pixels_sent] = want;
    pixels_sent++;
    if (want.invalid) pixels_bad++;
  endtask

  // Idle the input for a random gap between bursts of random length.
  int burst_left = 0;
  task automatic pace_input();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(24, 1);
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Output stalls: clear, fixed rotating pattern, heavy random, light random.
  always @(negedge clk_i) begin
    cycle_count <= cycle_count + 1;
    stall_pattern <= {stall_pattern[11:0], stall_pattern[12]};
    case ((cycle_count / 200) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= stall_pattern[12];
      2: m_axis_tready <= ($urandom_range(1) == 1);
      default: m_axis_tready <= ($urandom_range(9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      colors_seen++;
      if (colors_seen > pixels_sent) begin
        report_mismatch("unexpected word", int'(m_axis_tdata), 0);
      end else begin
        want = expected_colors[colors_seen-1];
        if (m_axis_tdata[7:0] !== want.red)
          report_mismatch("red", int'(m_axis_tdata[7:0]), int'(want.red));
        if (m_axis_tdata[15:8] !== want.green)
          report_mismatch("green", int'(m_axis_tdata[15:8]), int'(want.green));
        if (m_axis_tdata[23:16] !== want.blue)
          report_mismatch("blue", int'(m_axis_tdata[23:16]), int'(want.blue));
        if (m_axis_tuser !== want.invalid)
          report_mismatch("invalid", int'(m_axis_tuser), int'(want.invalid));
      end
    end
  end

  initial begin
    logic signed [HSV_HUE_W-1:0] hue;
    logic signed [HSV_PCT_W-1:0] sat;
    logic signed [HSV_PCT_W-1:0] val;
    rgb_t                        want;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i]) begin
      pace_input();
      want = DIRECTED[i].typed ? DIRECTED[i].want
                               : hsv_color(DIRECTED[i].hue, DIRECTED[i].sat, DIRECTED[i].val);
      push_pixel(DIRECTED[i].hue, DIRECTED[i].sat, DIRECTED[i].val, want);
    end

    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      pace_input();
      if ($urandom_range(99) < 85) begin
        hue = HSV_HUE_W'($urandom_range(HUE_FULL_TURN));
        // land on or next to a sector edge now and then
        if ($urandom_range(9) == 0)
          hue = HSV_HUE_W'($urandom_range(6) * HUE_PER_SECTOR -
                           ((hue % 2) * ($urandom_range(1) ? 1 : -1)));
        if (hue < 0 || hue > HUE_FULL_TURN) hue = '0;
        sat = HSV_PCT_W'($urandom_range(PCT_MAX));
        val = HSV_PCT_W'($urandom_range(PCT_MAX));
        if ($urandom_range(15) == 0) sat = $urandom_range(1) ? HSV_PCT_W'(PCT_MAX) : '0;
        if ($urandom_range(15) == 0) val = $urandom_range(1) ? HSV_PCT_W'(PCT_MAX) : '0;
      end else begin
        hue = HSV_HUE_W'($urandom);
        sat = HSV_PCT_W'($urandom);
        val = HSV_PCT_W'($urandom);
      end
      push_pixel(hue, sat, val, hsv_color(hue, sat, val));
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (colors_seen < pixels_sent) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d pixels (%0d out of range), %0d color words checked.",
             pixels_sent, pixels_bad, colors_seen);
    $display("Sector edges, range limits, bursty input and output stalls exercised.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d color words outstanding.", pixels_sent - colors_seen);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
